// ===== design/rmd_pkg.sv =====
// Shared rounding-mode and status codes for the rounded rescale core.
package rmd_pkg;

  localparam logic [2:0] MODE_ZERO = 3'd0;
  localparam logic [2:0] MODE_AWAY = 3'd1;
  localparam logic [2:0] MODE_DOWN = 3'd2;
  localparam logic [2:0] MODE_UP   = 3'd3;
  localparam logic [2:0] MODE_RSV4 = 3'd4;
  localparam logic [2:0] MODE_NEAR = 3'd5;
  localparam logic [2:0] MODE_RSV6 = 3'd6;
  localparam logic [2:0] MODE_RSV7 = 3'd7;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

endpackage

// ===== design/rescale_muldiv_rounded_core.sv =====
// Top level: pipelined rounded value*multiplier/divisor rescale.
//
// Usage: drive value, multiplier, divisor, rounding_mode and pass_extremes
// with start high for one cycle to issue a request. busy is always low, so
// a new request may be issued in every cycle.
// Each request yields one result on result/status, marked by done for
// exactly one cycle. Throughput is one request per cycle. The latency is
// set by the restoring divider, one quotient bit per pipeline stage
// (DATA_WIDTH-1 stages), behind a decode stage, a split partial-product
// multiplier (three stages) and a range check stage, plus the output
// register.
// Status: 0 ok, 1 invalid arguments, 2 overflow; result is the minimum
// integer on any error.
// Reset (rst, synchronous) clears all valid bits; requests in flight are
// dropped. The receiver cannot stall: done is a strobe and results are
// never held.
module rescale_muldiv_rounded_core #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] multiplier,
  input  logic [DATA_WIDTH-1:0] divisor,
  input  logic [2:0]            rounding_mode,
  input  logic                  pass_extremes,
  output logic [DATA_WIDTH-1:0] result,
  output logic [1:0]            status,
  output logic                  done
);

  localparam int W = DATA_WIDTH;
  localparam int M = DATA_WIDTH - 1;
  localparam int H = (DATA_WIDTH + 1) / 2;
  localparam logic [W-1:0] VMIN = {1'b1, {M{1'b0}}};
  localparam logic [W-1:0] VMAX = {1'b0, {M{1'b1}}};

  assign busy = 1'b0;

  // Decode: validity, extremes, magnitude, bias
  logic         inv, is_min, is_max, neg_in;
  logic [2:0]   mode_eff;
  logic [W-1:0] neg_val;
  logic [M-1:0] mag_in, r_in, c_in;

  always_comb begin
    inv = divisor[W-1] || (divisor == '0) || multiplier[W-1]
          || (rounding_mode == rmd_pkg::MODE_RSV4)
          || (rounding_mode == rmd_pkg::MODE_RSV6)
          || (rounding_mode == rmd_pkg::MODE_RSV7);
    is_min  = (value == VMIN);
    is_max  = (value == VMAX);
    neg_in  = value[W-1];
    neg_val = ~value + {{M{1'b0}}, 1'b1};
    c_in    = divisor[M-1:0];
    if (neg_in) begin
      mag_in = is_min ? VMAX[M-1:0] : neg_val[M-1:0];
    end else begin
      mag_in = value[M-1:0];
    end
    mode_eff = rounding_mode;
    if (neg_in && ((rounding_mode == rmd_pkg::MODE_DOWN) ||
                   (rounding_mode == rmd_pkg::MODE_UP))) begin
      mode_eff = rounding_mode ^ 3'd1;
    end
    priority if (mode_eff == rmd_pkg::MODE_NEAR) begin
      r_in = c_in >> 1;
    end else if (mode_eff[0]) begin
      r_in = c_in - {{(M-1){1'b0}}, 1'b1};
    end else begin
      r_in = '0;
    end
  end

  // Stage 0 registers
  logic         v0, e0, neg0;
  logic [W-1:0] er0;
  logic [1:0]   es0;
  logic [M-1:0] mag0, b0, c0, r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    e0   <= inv || (pass_extremes && (is_min || is_max));
    er0  <= inv ? VMIN : value;
    es0  <= inv ? rmd_pkg::STAT_INVALID : rmd_pkg::STAT_OK;
    neg0 <= neg_in;
    mag0 <= mag_in;
    b0   <= multiplier[M-1:0];
    c0   <= c_in;
    r0   <= r_in;
  end

  // Stage 1: four half-width partial products
  logic [2*H-1:0] ma, mb;
  assign ma = (2*H)'(mag0);
  assign mb = (2*H)'(b0);

  logic           v1, e1, neg1;
  logic [W-1:0]   er1;
  logic [1:0]     es1;
  logic [M-1:0]   c1, r1;
  logic [2*H-1:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    e1 <= e0; er1 <= er0; es1 <= es0; neg1 <= neg0; c1 <= c0; r1 <= r0;
    p00 <= ma[H-1:0]   * mb[H-1:0];
    p01 <= ma[H-1:0]   * mb[2*H-1:H];
    p10 <= ma[2*H-1:H] * mb[H-1:0];
    p11 <= ma[2*H-1:H] * mb[2*H-1:H];
  end

  // Stage 2: combine the cross terms
  logic           v2, e2, neg2;
  logic [W-1:0]   er2;
  logic [1:0]     es2;
  logic [M-1:0]   c2, r2;
  logic [2*H-1:0] q00, q11;
  logic [2*H:0]   mid2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    e2 <= e1; er2 <= er1; es2 <= es1; neg2 <= neg1; c2 <= c1; r2 <= r1;
    q00  <= p00;
    q11  <= p11;
    mid2 <= {1'b0, p01} + {1'b0, p10};
  end

  // Stage 3: full product plus rounding bias
  logic [4*H-1:0] sum3;
  assign sum3 = {q11, q00} + ((4*H)'(mid2) << H) + (4*H)'(r2);

  logic           v3, e3, neg3;
  logic [W-1:0]   er3;
  logic [1:0]     es3;
  logic [M-1:0]   c3;
  logic [2*W-1:0] n3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    e3 <= e2; er3 <= er2; es3 <= es2; neg3 <= neg2; c3 <= c2;
    n3 <= sum3[2*W-1:0];
  end

  // Stage 4: range check; the top bits seed the divider remainder
  logic [W:0] top3;
  logic       ovf3;
  assign top3 = n3[2*W-1:M];
  assign ovf3 = top3 >= {2'b00, c3};

  logic         d_v   [0:M];
  logic         d_e   [0:M];
  logic         d_neg [0:M];
  logic [W-1:0] d_er  [0:M];
  logic [1:0]   d_es  [0:M];
  logic [M-1:0] d_c   [0:M];
  logic [M-1:0] d_rem [0:M];
  logic [M-1:0] d_lo  [0:M];
  logic [M-1:0] d_q   [0:M];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v[0] <= 1'b0;
    end else begin
      d_v[0] <= v3;
    end
    d_e[0]   <= e3 || ovf3;
    d_er[0]  <= e3 ? er3 : VMIN;
    d_es[0]  <= e3 ? es3 : rmd_pkg::STAT_OVERFLOW;
    d_neg[0] <= neg3;
    d_c[0]   <= c3;
    d_rem[0] <= top3[M-1:0];
    d_lo[0]  <= n3[M-1:0];
    d_q[0]   <= '0;
  end

  // Divider: one restoring step per stage
  for (genvar k = 0; k < M; k++) begin : g_div
    logic [W-1:0] t, diff;
    logic         ge;
    assign t    = {d_rem[k], d_lo[k][M-1]};
    assign ge   = t >= {1'b0, d_c[k]};
    assign diff = t - {1'b0, d_c[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[k+1] <= 1'b0;
      end else begin
        d_v[k+1] <= d_v[k];
      end
      d_e[k+1]   <= d_e[k];
      d_er[k+1]  <= d_er[k];
      d_es[k+1]  <= d_es[k];
      d_neg[k+1] <= d_neg[k];
      d_c[k+1]   <= d_c[k];
      d_rem[k+1] <= ge ? diff[M-1:0] : t[M-1:0];
      d_lo[k+1]  <= d_lo[k] << 1;
      d_q[k+1]   <= {d_q[k][M-2:0], ge};
    end
  end

  // Output: apply sign or take the early result
  logic [W-1:0] qz;
  assign qz = {1'b0, d_q[M]};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_v[M];
    end
    if (d_e[M]) begin
      result <= d_er[M];
      status <= d_es[M];
    end else begin
      result <= d_neg[M] ? ('0 - qz) : qz;
      status <= rmd_pkg::STAT_OK;
    end
  end

endmodule

// ===== bench/rescale_muldiv_rounded_core_test.sv =====
// Self-checking bench for the rounded value*multiplier/divisor rescale core.
`timescale 1ns / 100ps

module rescale_muldiv_rounded_core_test;

  localparam int DW = 64;
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam int LATENCY = DW + 5;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [DW-1:0] result;
    logic [1:0]    status;
  } rescale_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [DW-1:0] value = '0;
  logic [DW-1:0] multiplier = '0;
  logic [DW-1:0] divisor = 64'd1;
  logic [2:0]    rounding_mode = rmd_pkg::MODE_ZERO;
  logic          pass_extremes = 1'b0;
  logic [DW-1:0] result;
  logic [1:0]    status;
  logic          done;

  rescale_t pending_q[$];
  int       fail_cnt = 0;
  longint   cycle_cnt = 0;
  bit       allow_idle = 1'b1;

  rescale_muldiv_rounded_core #(.DATA_WIDTH(DW)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .value(value), .multiplier(multiplier), .divisor(divisor),
    .rounding_mode(rounding_mode), .pass_extremes(pass_extremes),
    .result(result), .status(status), .done(done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Compute the rounded, range-checked quotient of one request
  function automatic rescale_t predict_rescale(logic [DW-1:0] a, logic [DW-1:0] b,
                                               logic [DW-1:0] c, logic [2:0] mode,
                                               logic pass);
    rescale_t      r;
    logic [DW-1:0] mag;
    logic [DW-1:0] bias;
    logic [2:0]    m;
    logic [2*DW:0] num;
    logic [2*DW:0] quo;
    logic          neg;
    m = mode;
    neg = a[DW-1];
    if (c[DW-1] || c == '0 || b[DW-1] || mode == rmd_pkg::MODE_RSV4 ||
        mode == rmd_pkg::MODE_RSV6 || mode == rmd_pkg::MODE_RSV7) begin
      r.result = VMIN; r.status = rmd_pkg::STAT_INVALID;
      return r;
    end
    if (pass && (a == VMIN || a == VMAX)) begin
      r.result = a; r.status = rmd_pkg::STAT_OK;
      return r;
    end
    if (neg) begin
      mag = (a == VMIN) ? VMAX : -a;
      if (m == rmd_pkg::MODE_DOWN) m = rmd_pkg::MODE_UP;
      else if (m == rmd_pkg::MODE_UP) m = rmd_pkg::MODE_DOWN;
    end else begin
      mag = a;
    end
    if (m == rmd_pkg::MODE_NEAR) bias = c >> 1;
    else if (m == rmd_pkg::MODE_AWAY || m == rmd_pkg::MODE_UP) bias = c - 64'd1;
    else bias = '0;
    num = ({{(DW+1){1'b0}}, mag} * {{(DW+1){1'b0}}, b}) + {{(DW+1){1'b0}}, bias};
    quo = num / {{(DW+1){1'b0}}, c};
    if (quo > {{(DW+1){1'b0}}, VMAX}) begin
      r.result = VMIN; r.status = rmd_pkg::STAT_OVERFLOW;
    end else begin
      r.result = neg ? -quo[DW-1:0] : quo[DW-1:0];
      r.status = rmd_pkg::STAT_OK;
    end
    return r;
  endfunction

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    rescale_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("result with no request pending: result=%h status=%0d", result, status);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (result !== want.result) begin
          $error("result mismatch: expected %h actual %h", want.result, result);
          fail_cnt++;
        end
        if (status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, status);
          fail_cnt++;
        end
      end
    end
  end

  // Drop start and idle for a random burst
  task automatic idle_burst();
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Issue one request and log its expected outcome
  task automatic send_request(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c,
                              logic [2:0] mode, logic pass);
    value <= a; multiplier <= b; divisor <= c;
    rounding_mode <= mode; pass_extremes <= pass; start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(predict_rescale(a, b, c, mode, pass));
    @(negedge clk);
    idle_burst();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DW-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [DW-1:0] rand_sized();
    logic [DW-1:0] w;
    w = rand_word();
    case ($urandom_range(0, 5))
      0: return w;
      1: return w >> $urandom_range(1, 63);
      2: return w & 64'hFFFF;
      3: return w >> 32;
      4: return VMAX - (w & 64'hF);
      default: return VMIN + (w & 64'hF);
    endcase
  endfunction

  function automatic logic [2:0] rand_valid_mode();
    case ($urandom_range(0, 4))
      0: return rmd_pkg::MODE_ZERO;
      1: return rmd_pkg::MODE_AWAY;
      2: return rmd_pkg::MODE_DOWN;
      3: return rmd_pkg::MODE_UP;
      default: return rmd_pkg::MODE_NEAR;
    endcase
  endfunction

  // Cover field extremes, each mode, invalid args and extreme passing
  task automatic test_directed();
    logic [2:0] m;
    for (int i = 0; i < 8; i++) begin
      m = i[2:0];
      send_request(-64'sd7, 64'd3, 64'd2, m, 1'b0);
    end
    send_request(64'd5, 64'd1, 64'd2, rmd_pkg::MODE_NEAR, 1'b0);
    send_request(-64'sd5, 64'd1, 64'd2, rmd_pkg::MODE_NEAR, 1'b0);
    send_request(64'd1, 64'd1, '0, rmd_pkg::MODE_ZERO, 1'b0);
    send_request(64'd1, 64'd1, VMIN, rmd_pkg::MODE_ZERO, 1'b0);
    send_request(64'd1, VMIN, 64'd1, rmd_pkg::MODE_ZERO, 1'b0);
    send_request(VMIN, 64'd1, 64'd1, rmd_pkg::MODE_ZERO, 1'b1);
    send_request(VMAX, 64'd9, 64'd1, rmd_pkg::MODE_UP, 1'b1);
    send_request(VMIN, 64'd1, 64'd1, rmd_pkg::MODE_DOWN, 1'b0);
    send_request(VMAX, VMAX, 64'd1, rmd_pkg::MODE_AWAY, 1'b0);
    send_request(VMAX, VMAX, VMAX, rmd_pkg::MODE_AWAY, 1'b0);
    send_request(VMAX, VMAX, 64'd2, rmd_pkg::MODE_ZERO, 1'b0);
    send_request(VMAX, 64'd2, 64'd3, rmd_pkg::MODE_NEAR, 1'b0);
    send_request('0, VMAX, VMAX, rmd_pkg::MODE_UP, 1'b1);
    send_request(-64'sd1, VMAX, 64'd1, rmd_pkg::MODE_DOWN, 1'b0);
  endtask

  // Random requests, mostly valid, with some invalid arguments mixed in
  task automatic test_random(int count);
    logic [DW-1:0] b;
    logic [DW-1:0] c;
    logic [2:0]    m;
    for (int i = 0; i < count; i++) begin
      b = rand_sized() & VMAX;
      c = (rand_sized() & VMAX) | 64'd1;
      m = rand_valid_mode();
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: c = c | VMIN;
          1: b = b | VMIN;
          default: m = 3'($urandom_range(0, 7));
        endcase
      end
      send_request(rand_sized(), b, c, m, 1'($urandom_range(0, 1)));
    end
  endtask

  // Sender holds off until the pipeline has emptied
  task automatic test_drain_pause();
    test_random(50);
    wait_drained();
    test_random(50);
  endtask

  // Back-to-back requests with no idling
  task automatic test_streaming();
    allow_idle = 1'b0;
    test_random(500);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1100);
    test_drain_pause();
    test_streaming();
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
